FILE: hw/rtl/fsdb_pkg.sv
// footswitch debounce and bypass control package
// payload structs, per-switch status struct, register indexes and limits
// no dependencies
package fsdb_pkg;

  localparam int unsigned NUM_SW   = 3;
  localparam int unsigned SW_MAIN  = 0;
  localparam int unsigned SW_EXT   = 1;
  localparam int unsigned SW_JACK  = 2;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LATCH    = 2'd2;

  localparam logic [7:0]  DEB_MAX   = 8'd253;
  localparam logic [15:0] LONG_MAX  = 16'd65534;
  localparam logic [7:0]  DEB_RST   = 8'd5;
  localparam logic [15:0] LONG_RST  = 16'd250;
  localparam logic [2:0]  LATCH_RST = 3'b110;

  typedef struct packed {
    logic main_open;
    logic ext_open;
    logic jack_open;
  } in_item_t;

  typedef struct packed {
    logic       effect_active;
    logic       learn_active;
    logic       relay_drive;
    logic [2:0] pressed_mask;
    logic [2:0] push_pulses;
    logic [2:0] release_pulses;
    logic [2:0] long_held_mask;
    logic [2:0] long_release_pulses;
  } out_item_t;

  typedef struct packed {
    logic debounced;
    logic push;
    logic rel;
    logic long_held;
    logic long_rel;
  } sw_status_t;

endpackage

FILE: hw/rtl/fsdb_debounce.sv
// single switch debouncer with long-press detection
// depends on fsdb_pkg
module fsdb_debounce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               open,
  input  logic [7:0]         lim,
  input  logic [15:0]        llim,
  input  logic               latched,
  output fsdb_pkg::sw_status_t status
);
  import fsdb_pkg::*;

  logic        deb_r, deb_nxt;
  logic        armed_r, armed_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic        long_r, long_nxt;
  logic        push, rel, long_rel;
  logic [8:0]  lim_p1;

  always_comb begin
    deb_nxt   = deb_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    hold_nxt  = hold_r;
    long_nxt  = long_r;
    push      = 1'b0;
    rel       = 1'b0;
    long_rel  = 1'b0;
    lim_p1    = {1'b0, lim} + 9'd1;
    if (open == deb_r) begin
      if (!armed_r) begin
        armed_nxt = 1'b1;
      end else if (cnt_r == lim) begin
        rel     = open;
        push    = !open;
        cnt_nxt = cnt_r + 8'd1;
      end else if ({1'b0, cnt_r} == lim_p1) begin
        armed_nxt = 1'b0;
        deb_nxt   = !open;
        cnt_nxt   = 8'd0;
      end else begin
        cnt_nxt = cnt_r + 8'd1;
      end
    end else begin
      armed_nxt = 1'b0;
      cnt_nxt   = 8'd0;
    end
    if (!latched) begin
      if (deb_nxt) begin
        if (hold_r < llim) begin
          hold_nxt = hold_r + 16'd1;
        end else if (hold_r == llim) begin
          long_nxt = 1'b1;
          hold_nxt = hold_r + 16'd1;
        end
      end else begin
        long_rel = long_r;
        long_nxt = 1'b0;
        hold_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r   <= 1'b0;
      armed_r <= 1'b0;
      cnt_r   <= 8'd0;
      hold_r  <= 16'd0;
      long_r  <= 1'b0;
    end else if (step) begin
      deb_r   <= deb_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
      long_r  <= long_nxt;
    end
  end

  assign status = '{debounced: deb_nxt, push: push, rel: rel,
                    long_held: long_nxt, long_rel: long_rel};

endmodule

FILE: hw/rtl/fsdb_mode.sv
// effect and learn mode control from debounced switch events
// depends on fsdb_pkg
module fsdb_mode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  fsdb_pkg::sw_status_t main_st,
  input  fsdb_pkg::sw_status_t ext_st,
  input  fsdb_pkg::sw_status_t jack_st,
  output logic                 effect_nxt,
  output logic                 learn_nxt
);
  import fsdb_pkg::*;

  logic effect_r, learn_r;

  always_comb begin
    effect_nxt = effect_r;
    learn_nxt  = learn_r;
    if (main_st.push) begin
      if (!learn_r) effect_nxt = !effect_r;
    end else if (main_st.long_rel && effect_r) begin
      if (!learn_r) effect_nxt = 1'b0;
    end
    if (!effect_nxt) begin
      if (ext_st.push) effect_nxt = 1'b1;
      else if (ext_st.rel) effect_nxt = 1'b0;
    end
    if (!learn_r && main_st.long_held && jack_st.debounced) begin
      learn_nxt  = 1'b1;
      effect_nxt = 1'b0;
    end else if (learn_r && main_st.push) begin
      learn_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= 1'b0;
      learn_r  <= 1'b0;
    end else if (step) begin
      effect_r <= effect_nxt;
      learn_r  <= learn_nxt;
    end
  end

endmodule

FILE: hw/rtl/footswitch_debounce_bypass_control.sv
// footswitch debounce and bypass control, top level
// one tick per cycle sustained while out_ready is high
// input register, then switch and mode logic into the result register
// synchronous active-low reset clears all switch state, flags and config to defaults
// depends on fsdb_pkg, fsdb_debounce, fsdb_mode
module footswitch_debounce_bypass_control (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fsdb_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fsdb_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fsdb_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [fsdb_pkg::CFG_DW-1:0]         cfg_wdata
);
  import fsdb_pkg::*;

  logic [7:0]  deb_ticks_r;
  logic [15:0] long_ticks_r;
  logic [2:0]  latch_r;
  logic        stg_v_r;
  in_item_t    stg_r;
  logic        out_v_r;
  out_item_t   out_r;
  logic        out_free, move;
  logic [7:0]  lim;
  logic [15:0] llim;
  logic [2:0]  raw_open;
  sw_status_t  st [NUM_SW];
  logic        effect_nxt, learn_nxt;
  out_item_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= DEB_RST;
      long_ticks_r <= LONG_RST;
      latch_r      <= LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: deb_ticks_r  <= cfg_wdata[7:0];
        CFG_LONG:     long_ticks_r <= cfg_wdata;
        CFG_LATCH:    latch_r      <= cfg_wdata[2:0];
        default:      ;
      endcase
    end
  end

  assign out_free = !out_v_r || out_ready;
  assign move     = stg_v_r && out_free;
  assign in_ready = !stg_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_v_r <= 1'b1;
    end else if (move) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg_r <= in_data;
  end

  assign lim      = (deb_ticks_r > DEB_MAX) ? DEB_MAX : deb_ticks_r;
  assign llim     = (long_ticks_r > LONG_MAX) ? LONG_MAX : long_ticks_r;
  assign raw_open = {stg_r.jack_open, stg_r.ext_open, stg_r.main_open};

  for (genvar i = 0; i < NUM_SW; i++) begin : g_sw
    fsdb_debounce u_deb (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (move),
      .open    (raw_open[i]),
      .lim     (lim),
      .llim    (llim),
      .latched (latch_r[i]),
      .status  (st[i])
    );
  end

  fsdb_mode u_mode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (move),
    .main_st    (st[SW_MAIN]),
    .ext_st     (st[SW_EXT]),
    .jack_st    (st[SW_JACK]),
    .effect_nxt (effect_nxt),
    .learn_nxt  (learn_nxt)
  );

  always_comb begin
    res.effect_active = effect_nxt;
    res.learn_active  = learn_nxt;
    res.relay_drive   = effect_nxt && !learn_nxt;
    for (int i = 0; i < NUM_SW; i++) begin
      res.pressed_mask[i]        = st[i].debounced;
      res.push_pulses[i]         = st[i].push;
      res.release_pulses[i]      = st[i].rel;
      res.long_held_mask[i]      = st[i].long_held;
      res.long_release_pulses[i] = st[i].long_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= stg_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/fsdb_checker.sv
// port-level checks for the footswitch debounce and bypass control
// depends on fsdb_pkg, bound to footswitch_debounce_bypass_control
module fsdb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input fsdb_pkg::out_item_t out_data
);
  import fsdb_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.relay_drive ==
                  (out_data.effect_active && !out_data.learn_active))
    else $error("relay drive mismatch");

  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.push_pulses & out_data.release_pulses) == 3'b000)
    else $error("push and release on the same switch");

  a_long_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.long_release_pulses &
                    (out_data.pressed_mask | out_data.long_held_mask)) == 3'b000))
    else $error("long release while still pressed or held");

endmodule

bind footswitch_debounce_bypass_control fsdb_checker u_fsdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/footswitch_debounce_bypass_control_test.sv
// testbench for footswitch_debounce_bypass_control: queue-fed driver, monitor and tick predictor
// depends on fsdb_pkg and the footswitch_debounce_bypass_control rtl
`timescale 1ns / 100ps

module footswitch_debounce_bypass_control_test;
  import fsdb_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // predictor copy of config and switch state
  logic [7:0] deb_reg = DEB_RST;
  logic [15:0] long_reg = LONG_RST;
  logic [2:0] latch_reg = LATCH_RST;
  logic sw_pressed [NUM_SW] = '{default: 1'b0};
  logic sw_armed [NUM_SW] = '{default: 1'b0};
  logic [7:0] bounce [NUM_SW] = '{default: 8'd0};
  logic [15:0] hold [NUM_SW] = '{default: 16'd0};
  logic held [NUM_SW] = '{default: 1'b0};
  logic effect_on = 1'b0;
  logic learn_on = 1'b0;

  // raw switch levels of the stimulus, 1 means open
  logic raw_lvl [NUM_SW] = '{default: 1'b1};
  int run_left [NUM_SW] = '{default: 0};

  in_item_t tick_q [$];
  out_item_t result_q [$];
  int n_loaded = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  footswitch_debounce_bypass_control u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int deb_limit();
    return (deb_reg > DEB_MAX) ? int'(DEB_MAX) : int'(deb_reg);
  endfunction

  function automatic int long_limit();
    return (long_reg > LONG_MAX) ? int'(LONG_MAX) : int'(long_reg);
  endfunction

  function automatic out_item_t tick_predict(in_item_t t);
    logic [2:0] raw_open, push, rel, lrel;
    logic sw_long, push_edge, jack_in;
    int lim, llim;
    out_item_t r;
    raw_open = {t.jack_open, t.ext_open, t.main_open};
    lim = deb_limit();
    llim = long_limit();
    push = '0;
    rel = '0;
    lrel = '0;
    for (int i = 0; i < NUM_SW; i++) begin
      if (raw_open[i] == sw_pressed[i]) begin
        if (!sw_armed[i]) begin
          sw_armed[i] = 1'b1;
        end else if (int'(bounce[i]) == lim) begin
          if (raw_open[i]) rel[i] = 1'b1;
          else push[i] = 1'b1;
          bounce[i] = bounce[i] + 8'd1;
        end else if (int'(bounce[i]) == lim + 1) begin
          sw_armed[i] = 1'b0;
          sw_pressed[i] = !raw_open[i];
          bounce[i] = 8'd0;
        end else begin
          bounce[i] = bounce[i] + 8'd1;
        end
      end else begin
        sw_armed[i] = 1'b0;
        bounce[i] = 8'd0;
      end
      if (!latch_reg[i]) begin
        if (sw_pressed[i]) begin
          if (int'(hold[i]) < llim) begin
            hold[i] = hold[i] + 16'd1;
          end else if (int'(hold[i]) == llim) begin
            held[i] = 1'b1;
            hold[i] = hold[i] + 16'd1;
          end
        end else begin
          if (held[i]) lrel[i] = 1'b1;
          held[i] = 1'b0;
          hold[i] = 16'd0;
        end
      end
    end
    sw_long = 1'b0;
    jack_in = 1'b0;
    push_edge = 1'b0;
    if (push[SW_MAIN]) begin
      if (!learn_on) effect_on = !effect_on;
      push_edge = 1'b1;
    end else if (lrel[SW_MAIN] && effect_on) begin
      if (!learn_on) effect_on = 1'b0;
    end
    // ext switch only acts while the effect is off
    if (!effect_on) begin
      if (push[SW_EXT]) effect_on = 1'b1;
      else if (rel[SW_EXT]) effect_on = 1'b0;
    end
    if (!learn_on) begin
      sw_long = held[SW_MAIN];
      jack_in = sw_pressed[SW_JACK];
    end
    if (sw_long && jack_in) begin
      learn_on = 1'b1;
      effect_on = 1'b0;
    end else if (learn_on && push_edge) begin
      learn_on = 1'b0;
    end
    r.effect_active = effect_on;
    r.learn_active = learn_on;
    r.relay_drive = effect_on && !learn_on;
    r.pressed_mask = {sw_pressed[2], sw_pressed[1], sw_pressed[0]};
    r.push_pulses = push;
    r.release_pulses = rel;
    r.long_held_mask = {held[2], held[1], held[0]};
    r.long_release_pulses = lrel;
    return r;
  endfunction

  task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10) $display("mismatch %s: expected %0h got %0h", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result transfer %p", out_data);
        end else begin
          want = result_q.pop_front();
          check_field("effect_active", {2'b00, want.effect_active},
                      {2'b00, out_data.effect_active});
          check_field("learn_active", {2'b00, want.learn_active},
                      {2'b00, out_data.learn_active});
          check_field("relay_drive", {2'b00, want.relay_drive},
                      {2'b00, out_data.relay_drive});
          check_field("pressed_mask", want.pressed_mask, out_data.pressed_mask);
          check_field("push_pulses", want.push_pulses, out_data.push_pulses);
          check_field("release_pulses", want.release_pulses, out_data.release_pulses);
          check_field("long_held_mask", want.long_held_mask, out_data.long_held_mask);
          check_field("long_release_pulses", want.long_release_pulses,
                      out_data.long_release_pulses);
        end
      end
      if (in_valid && in_ready) begin
        result_q.push_back(tick_predict(in_data));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    while (n_accepted != n_loaded || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: deb_reg = data[7:0];
      CFG_LONG:     long_reg = data;
      CFG_LATCH:    latch_reg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic queue_hold(logic m, logic e, logic j, int n);
    in_item_t t;
    t.main_open = m;
    t.ext_open = e;
    t.jack_open = j;
    raw_lvl[0] = m;
    raw_lvl[1] = e;
    raw_lvl[2] = j;
    repeat (n) begin
      tick_q.push_back(t);
      n_loaded++;
    end
  endtask

  // runs of held levels sized around the debounce and long-press limits, with glitches
  task automatic queue_random(int n);
    int lim, span, pick;
    in_item_t t;
    lim = deb_limit();
    span = lim + long_limit() + 16;
    if (span > 320) span = 320;
    repeat (n) begin
      for (int i = 0; i < NUM_SW; i++) begin
        if (run_left[i] == 0) begin
          raw_lvl[i] = !raw_lvl[i];
          pick = $urandom_range(99);
          if (pick < 20) run_left[i] = $urandom_range(lim + 1, 1);
          else run_left[i] = $urandom_range(lim + 2 + span, lim + 2);
        end
        run_left[i]--;
      end
      t.main_open = raw_lvl[0];
      t.ext_open = raw_lvl[1];
      t.jack_open = raw_lvl[2];
      if ($urandom_range(99) < 3) t[$urandom_range(2)] ^= 1'b1;
      tick_q.push_back(t);
      n_loaded++;
    end
  endtask

  task automatic run_phase(logic [CFG_DW-1:0] deb, logic [CFG_DW-1:0] lng,
                           logic [CFG_DW-1:0] latch, int n, int send_pct, int recv_pct);
    wait_idle();
    cfg_write(CFG_DEBOUNCE, deb);
    cfg_write(CFG_LONG, lng);
    cfg_write(CFG_LATCH, latch);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fastest debounce, immediate long press, all momentary
    cfg_write(CFG_DEBOUNCE, 16'd0);
    cfg_write(CFG_LONG, 16'd0);
    cfg_write(CFG_LATCH, 16'd0);
    queue_hold(1'b1, 1'b1, 1'b1, 1);
    queue_hold(1'b0, 1'b1, 1'b0, 3);   // main long with jack in, enters learn
    queue_hold(1'b0, 1'b0, 1'b0, 3);   // ext push during learn turns effect on
    queue_hold(1'b1, 1'b0, 1'b0, 3);   // main long release in learn
    queue_hold(1'b0, 1'b0, 1'b0, 3);   // main push leaves learn
    queue_hold(1'b1, 1'b0, 1'b0, 1);   // glitch away from the debounced level
    queue_hold(1'b0, 1'b0, 1'b0, 2);
    queue_hold(1'b1, 1'b1, 1'b1, 4);

    run_phase(16'd5, 16'd250, 16'd6, 400, 0, 0);
    run_phase(16'd0, 16'd0, 16'd0, 200, 49, 0);
    run_phase(16'd2, 16'd7, 16'd5, 250, 0, 49);
    wait_idle();
    cfg_write(CFG_UNUSED, 16'hA5C3);
    run_phase(16'd1, 16'd3, 16'd3, 250, 13, 13);
    run_phase(16'hFFFE, 16'hFFFF, 16'hFFFF, 250, 0, 0);
    run_phase(16'h5A03, 16'd12, 16'd0, 300, 49, 0);
    run_phase(16'd4, 16'd20, 16'd2, 200, 13, 13);

    wait_idle();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: footswitch_debounce_bypass_control.f
hw/rtl/fsdb_pkg.sv
hw/rtl/fsdb_debounce.sv
hw/rtl/fsdb_mode.sv
hw/rtl/footswitch_debounce_bypass_control.sv
hw/rtl/fsdb_checker.sv
tb/sv/footswitch_debounce_bypass_control_test.sv
